/* rtl/core/dcrc_pkg.sv */
// Shared types, constants and CRC functions for the dual-CRC record codec.
`default_nettype none
package dcrc_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned CRC_W         = 16;
    localparam int unsigned FIELD_WORDS   = 7;
    localparam int unsigned RECORD_WORDS  = 8;
    localparam int unsigned POS_W         = 3;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned QUEUE_AW      = 1;
    localparam int unsigned QUEUE_CW      = 2;

    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]  MODBUS_POLY = 16'hA001;
    localparam logic [CRC_W-1:0]  CCITT_POLY  = 16'h1021;
    localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

    localparam logic [POS_W-1:0]  LAST_POS    = 3'd7;

    localparam logic OP_PACK  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic KIND_RECORD_WORD = 1'b0;
    localparam logic KIND_VERDICT     = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_EMPTY      = 2'd0,
        VERDICT_HALF       = 2'd1,
        VERDICT_UNFINISHED = 2'd2,
        VERDICT_OK         = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        ITEM_PACK       = 2'd0,
        ITEM_CHECK_MID  = 2'd1,
        ITEM_CHECK_LAST = 2'd2
    } t_item_kind;

    // One queued item: pack uses all words, check uses words[0] as the slot word
    typedef struct packed {
        t_item_kind                      kind;
        logic [FIELD_WORDS-1:0][WORD_W-1:0] words;
    } t_entry;

    // MODBUS CRC over a 32-bit word, bytes low first, bits LSB first
    function automatic logic [CRC_W-1:0] modbus_word(input logic [CRC_W-1:0] crc_in,
                                                     input logic [WORD_W-1:0] data);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int i = 0; i < WORD_W; i++) begin
            fb  = crc[0] ^ data[i];
            crc = {1'b0, crc[CRC_W-1:1]};
            if (fb) begin
                crc = crc ^ MODBUS_POLY;
            end
        end
        return crc;
    endfunction

    // CCITT-FALSE CRC over the low nbytes of a word, bytes low first, bits MSB first
    function automatic logic [CRC_W-1:0] ccitt_bytes(input logic [CRC_W-1:0] crc_in,
                                                     input logic [WORD_W-1:0] data,
                                                     input int unsigned nbytes);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int k = 0; k < 4; k++) begin
            if (k < nbytes) begin
                for (int b = 7; b >= 0; b--) begin
                    fb  = crc[CRC_W-1] ^ data[8*k+b];
                    crc = {crc[CRC_W-2:0], 1'b0};
                    if (fb) begin
                        crc = crc ^ CCITT_POLY;
                    end
                end
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/dual_crc_record_codec_core.sv */
// Top level of the dual-CRC record codec: front end, queue and back end.
// An accepted beat is written into the queue; a record word or verdict is then loaded from
// the queue head into the output register once it is free (mid slot words give no output).
// Throughput: one slot word per cycle while the queue has room; a pack item emits eight record
// words, one per cycle while not stalled, through the back end's single output register.
// Reset (i_rst_n, synchronous, active low) empties the queue, drops the output beat and
// returns the check CRCs, erased flag and word position to their start values.
`default_nettype none
module dual_crc_record_codec_core
    import dcrc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_operation,
    input  wire logic [WORD_W-1:0]        i_sequence_number,
    input  wire logic [WORD_W-1:0]        i_time_seconds,
    input  wire logic signed [WORD_W-1:0] i_temperature_value,
    input  wire logic [WORD_W-1:0]        i_humidity_value,
    input  wire logic [WORD_W-1:0]        i_pressure_value,
    input  wire logic [WORD_W-1:0]        i_adc_first,
    input  wire logic [WORD_W-1:0]        i_adc_second,
    input  wire logic [WORD_W-1:0]        i_slot_word,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_result_kind,
    output logic [WORD_W-1:0]             o_packed_word,
    output logic [1:0]                    o_slot_verdict,
    output logic                          o_last_word
);

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_entry push_entry;
    t_entry head_entry;

    assign o_stall = q_full;

    dcrc_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .i_operation         (i_operation),
        .i_sequence_number   (i_sequence_number),
        .i_time_seconds      (i_time_seconds),
        .i_temperature_value (i_temperature_value),
        .i_humidity_value    (i_humidity_value),
        .i_pressure_value    (i_pressure_value),
        .i_adc_first         (i_adc_first),
        .i_adc_second        (i_adc_second),
        .i_slot_word         (i_slot_word),
        .i_queue_full        (q_full),
        .o_push              (push),
        .o_entry             (push_entry)
    );

    dcrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    dcrc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_entry),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_packed_word  (o_packed_word),
        .o_slot_verdict (o_slot_verdict),
        .o_last_word    (o_last_word)
    );

endmodule
`default_nettype wire

/* rtl/core/dcrc_front.sv */
// Front end: takes input beats, tracks slot word position and tags each item.
`default_nettype none
module dcrc_front
    import dcrc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_operation,
    input  wire logic [WORD_W-1:0]   i_sequence_number,
    input  wire logic [WORD_W-1:0]   i_time_seconds,
    input  wire logic signed [WORD_W-1:0] i_temperature_value,
    input  wire logic [WORD_W-1:0]   i_humidity_value,
    input  wire logic [WORD_W-1:0]   i_pressure_value,
    input  wire logic [WORD_W-1:0]   i_adc_first,
    input  wire logic [WORD_W-1:0]   i_adc_second,
    input  wire logic [WORD_W-1:0]   i_slot_word,
    input  wire logic                i_queue_full,
    output logic                     o_push,
    output t_entry                   o_entry
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    // accept when the queue has room
    assign o_push = i_valid && !i_queue_full;

    // classify the beat and build the queue entry
    always_comb begin
        o_entry = '0;
        n_pos   = r_pos;
        if (i_operation == OP_PACK) begin
            o_entry.kind     = ITEM_PACK;
            o_entry.words[0] = i_sequence_number;
            o_entry.words[1] = i_time_seconds;
            o_entry.words[2] = i_temperature_value;
            o_entry.words[3] = i_humidity_value;
            o_entry.words[4] = i_pressure_value;
            o_entry.words[5] = i_adc_first;
            o_entry.words[6] = i_adc_second;
            n_pos            = '0;
        end else begin
            o_entry.kind     = (r_pos == LAST_POS) ? ITEM_CHECK_LAST : ITEM_CHECK_MID;
            o_entry.words[0] = i_slot_word;
            n_pos            = r_pos + 1'b1;
        end
    end

    // slot word position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/dcrc_queue.sv */
// Two-entry queue between the front end and the back end.
`default_nettype none
module dcrc_queue
    import dcrc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/dcrc_back.sv */
// Back end: emits record words and slot verdicts, runs the check CRCs and drives the output register.
`default_nettype none
module dcrc_back
    import dcrc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  wire t_entry             i_head,
    output logic                    o_pop,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic                    o_result_kind,
    output logic [WORD_W-1:0]       o_packed_word,
    output logic [1:0]              o_slot_verdict,
    output logic                    o_last_word
);

    logic [POS_W-1:0]  r_beat,  n_beat;
    logic [CRC_W-1:0]  r_head,  n_head;
    logic [CRC_W-1:0]  r_tail,  n_tail;
    logic              r_erased, n_erased;
    logic              r_valid, n_valid;
    logic              r_kind,  n_kind;
    logic [WORD_W-1:0] r_word,  n_word;
    t_verdict          r_verdict, n_verdict;
    logic              r_last,  n_last;

    logic              out_free;
    logic [CRC_W-1:0]  base_head;
    logic [CRC_W-1:0]  base_tail;
    logic [WORD_W-1:0] cur_word;
    logic [CRC_W-1:0]  tail_fin;
    logic              erased_fin;

    assign out_free  = !r_valid || !i_stall;
    assign base_head = (r_beat == '0) ? CRC_INIT : r_head;
    assign base_tail = (r_beat == '0) ? CRC_INIT : r_tail;
    assign cur_word  = i_head.words[0];
    // tail CRC closed over the two head CRC bytes (pack) or stored bytes (check)
    assign tail_fin  = (i_head.kind == ITEM_PACK)
                     ? ccitt_bytes(r_tail, {16'h0000, r_head}, 2)
                     : ccitt_bytes(r_tail, cur_word, 2);
    assign erased_fin = r_erased && (cur_word == ERASED_WORD);

    // item sequencing
    always_comb begin
        n_beat    = r_beat;
        n_head    = r_head;
        n_tail    = r_tail;
        n_erased  = r_erased;
        n_valid   = r_valid && i_stall;
        n_kind    = r_kind;
        n_word    = r_word;
        n_verdict = r_verdict;
        n_last    = r_last;
        o_pop     = 1'b0;
        if (!i_empty) begin
            case (i_head.kind)
                ITEM_PACK: begin
                    if (out_free) begin
                        n_valid   = 1'b1;
                        n_kind    = KIND_RECORD_WORD;
                        n_verdict = VERDICT_EMPTY;
                        if (r_beat == LAST_POS) begin
                            n_word   = {tail_fin, r_head};
                            n_last   = 1'b1;
                            o_pop    = 1'b1;
                            n_beat   = '0;
                            n_head   = CRC_INIT;
                            n_tail   = CRC_INIT;
                            n_erased = 1'b1;
                        end else begin
                            n_word = i_head.words[r_beat];
                            n_last = 1'b0;
                            n_head = modbus_word(base_head, i_head.words[r_beat]);
                            n_tail = ccitt_bytes(base_tail, i_head.words[r_beat], 4);
                            n_beat = r_beat + 1'b1;
                        end
                    end
                end
                ITEM_CHECK_MID: begin
                    o_pop    = 1'b1;
                    n_head   = modbus_word(r_head, cur_word);
                    n_tail   = ccitt_bytes(r_tail, cur_word, 4);
                    n_erased = r_erased && (cur_word == ERASED_WORD);
                end
                ITEM_CHECK_LAST: begin
                    if (out_free) begin
                        o_pop    = 1'b1;
                        n_valid  = 1'b1;
                        n_kind   = KIND_VERDICT;
                        n_word   = '0;
                        n_last   = 1'b0;
                        if (erased_fin) begin
                            n_verdict = VERDICT_EMPTY;
                        end else if (r_head != cur_word[CRC_W-1:0]) begin
                            n_verdict = VERDICT_HALF;
                        end else if (tail_fin != cur_word[WORD_W-1:CRC_W]) begin
                            n_verdict = VERDICT_UNFINISHED;
                        end else begin
                            n_verdict = VERDICT_OK;
                        end
                        n_head   = CRC_INIT;
                        n_tail   = CRC_INIT;
                        n_erased = 1'b1;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat   <= '0;
            r_head   <= CRC_INIT;
            r_tail   <= CRC_INIT;
            r_erased <= 1'b1;
            r_valid  <= 1'b0;
        end else begin
            r_beat   <= n_beat;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_erased <= n_erased;
            r_valid  <= n_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_word    <= n_word;
        r_verdict <= n_verdict;
        r_last    <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_result_kind  = r_kind;
    assign o_packed_word  = r_word;
    assign o_slot_verdict = r_verdict;
    assign o_last_word    = r_last;

endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for the dual-CRC record codec: directed and random pack and slot-check traffic.
`timescale 1ns / 1ps
module tb;
    import dcrc_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 450;
    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef logic [RECORD_WORDS-1:0][WORD_W-1:0] record_t;
    typedef logic [FIELD_WORDS-1:0][WORD_W-1:0]  fields_t;

    // One input beat as driven on the ports
    typedef struct packed {
        logic        op;
        fields_t     fields;
        logic [31:0] slot;
    } codec_item_t;

    // One output beat as the block should present it
    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic [1:0]  verdict;
        logic        last;
    } codec_beat_t;

    logic              i_clk;
    logic              i_rst_n             = 1'b0;
    logic              i_valid             = 1'b0;
    logic              o_stall;
    logic              i_operation         = OP_PACK;
    logic [31:0]       i_sequence_number   = '0;
    logic [31:0]       i_time_seconds      = '0;
    logic signed [31:0] i_temperature_value = '0;
    logic [31:0]       i_humidity_value    = '0;
    logic [31:0]       i_pressure_value    = '0;
    logic [31:0]       i_adc_first         = '0;
    logic [31:0]       i_adc_second        = '0;
    logic [31:0]       i_slot_word         = '0;
    logic              o_valid;
    logic              i_stall             = 1'b0;
    logic              o_result_kind;
    logic [31:0]       o_packed_word;
    logic [1:0]        o_slot_verdict;
    logic              o_last_word;

    dual_crc_record_codec_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_operation         (i_operation),
        .i_sequence_number   (i_sequence_number),
        .i_time_seconds      (i_time_seconds),
        .i_temperature_value (i_temperature_value),
        .i_humidity_value    (i_humidity_value),
        .i_pressure_value    (i_pressure_value),
        .i_adc_first         (i_adc_first),
        .i_adc_second        (i_adc_second),
        .i_slot_word         (i_slot_word),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_kind       (o_result_kind),
        .o_packed_word       (o_packed_word),
        .o_slot_verdict      (o_slot_verdict),
        .o_last_word         (o_last_word)
    );

    // Slot checker state mirrored on the bench side
    logic [POS_W-1:0] chk_pos;
    logic [15:0]      chk_head;
    logic [15:0]      chk_tail;
    logic             chk_erased;

    codec_beat_t pending_beats[$];
    codec_beat_t want_beat;

    int unsigned items_sent    = 0;
    int unsigned words_seen    = 0;
    int unsigned verdict_seen[4];
    int unsigned errors        = 0;
    int unsigned idle_cycles   = 0;
    int unsigned stall_left    = 0;
    logic        src_steady    = 1'b0;
    logic        sink_steady   = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] modbus_byte_upd(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ MODBUS_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] ccitt_byte_upd(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CCITT_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] modbus_word_upd(input logic [15:0] crc, input logic [31:0] w);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 4; k++) begin
            c = modbus_byte_upd(c, w[8*k +: 8]);
        end
        return c;
    endfunction

    function automatic logic [15:0] ccitt_word_upd(input logic [15:0] crc, input logic [31:0] w);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 4; k++) begin
            c = ccitt_byte_upd(c, w[8*k +: 8]);
        end
        return c;
    endfunction

    // Full 32-byte record: seven values, head CRC, tail CRC
    function automatic record_t build_record(input fields_t f);
        record_t     rec;
        logic [15:0] head;
        logic [15:0] tail;
        head = CRC_INIT;
        tail = CRC_INIT;
        for (int k = 0; k < FIELD_WORDS; k++) begin
            rec[k] = f[k];
            head   = modbus_word_upd(head, f[k]);
            tail   = ccitt_word_upd(tail, f[k]);
        end
        tail = ccitt_byte_upd(tail, head[7:0]);
        tail = ccitt_byte_upd(tail, head[15:8]);
        rec[RECORD_WORDS-1] = {tail, head};
        return rec;
    endfunction

    task automatic clear_checker();
        chk_pos    = '0;
        chk_head   = CRC_INIT;
        chk_tail   = CRC_INIT;
        chk_erased = 1'b1;
    endtask

    // Predict the output beats caused by one accepted item
    task automatic derive_codec_beats(input codec_item_t it);
        record_t     rec;
        codec_beat_t b;
        logic [15:0] tail;
        if (it.op == OP_PACK) begin
            rec = build_record(it.fields);
            for (int k = 0; k < RECORD_WORDS; k++) begin
                b.kind    = KIND_RECORD_WORD;
                b.word    = rec[k];
                b.verdict = VERDICT_EMPTY;
                b.last    = (k == RECORD_WORDS - 1);
                pending_beats.push_back(b);
            end
            clear_checker();
        end else begin
            if (it.slot != ERASED_WORD) begin
                chk_erased = 1'b0;
            end
            if (chk_pos != LAST_POS) begin
                chk_head = modbus_word_upd(chk_head, it.slot);
                chk_tail = ccitt_word_upd(chk_tail, it.slot);
                chk_pos  = chk_pos + 1'b1;
            end else begin
                tail = ccitt_byte_upd(chk_tail, it.slot[7:0]);
                tail = ccitt_byte_upd(tail, it.slot[15:8]);
                b.kind = KIND_VERDICT;
                b.word = '0;
                b.last = 1'b0;
                if (chk_erased) begin
                    b.verdict = VERDICT_EMPTY;
                end else if (chk_head != it.slot[15:0]) begin
                    b.verdict = VERDICT_HALF;
                end else if (tail != it.slot[31:16]) begin
                    b.verdict = VERDICT_UNFINISHED;
                end else begin
                    b.verdict = VERDICT_OK;
                end
                pending_beats.push_back(b);
                clear_checker();
            end
        end
    endtask

    // Idle lengths: mostly short, a few long
    function automatic int unsigned pick_idle();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Field value with a bias toward the extremes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic fields_t rand_fields();
        fields_t f;
        for (int k = 0; k < FIELD_WORDS; k++) begin
            f[k] = rand_word();
        end
        return f;
    endfunction

    // Item with random content on every data port, including the ones that get ignored
    function automatic codec_item_t junk_item();
        codec_item_t it;
        it.op = OP_CHECK;
        for (int k = 0; k < FIELD_WORDS; k++) begin
            it.fields[k] = $urandom;
        end
        it.slot = $urandom;
        return it;
    endfunction

    // Drive one beat and hold it until accepted; called and returns at a rising edge
    task automatic send_item(input codec_item_t it);
        int unsigned gap;
        gap = 0;
        if (!src_steady && $urandom_range(0, 99) < 45) begin
            gap = pick_idle();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_operation         <= it.op;
        i_sequence_number   <= it.fields[0];
        i_time_seconds      <= it.fields[1];
        i_temperature_value <= it.fields[2];
        i_humidity_value    <= it.fields[3];
        i_pressure_value    <= it.fields[4];
        i_adc_first         <= it.fields[5];
        i_adc_second        <= it.fields[6];
        i_slot_word         <= it.slot;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        items_sent++;
        derive_codec_beats(it);
    endtask

    task automatic send_pack(input fields_t f);
        codec_item_t it;
        it        = junk_item();
        it.op     = OP_PACK;
        it.fields = f;
        send_item(it);
    endtask

    task automatic send_slot(input logic [31:0] w);
        codec_item_t it;
        it      = junk_item();
        it.op   = OP_CHECK;
        it.slot = w;
        send_item(it);
    endtask

    task automatic send_slot_record(input record_t rec);
        for (int k = 0; k < RECORD_WORDS; k++) begin
            send_slot(rec[k]);
        end
    endtask

    // Output stall: random stretches, no new stretch starts while the sink runs steady
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (!sink_steady && $urandom_range(0, 99) < 25) begin
                stall_left = pick_idle();
            end
        end
    end

    // Result checker: each accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected beat: kind=%0d word=%h verdict=%0d last=%0d",
                             o_result_kind, o_packed_word, o_slot_verdict, o_last_word);
                end
            end else begin
                want_beat = pending_beats.pop_front();
                if (want_beat.kind == KIND_VERDICT) begin
                    verdict_seen[want_beat.verdict]++;
                end else begin
                    words_seen++;
                end
                if (o_result_kind !== want_beat.kind || o_packed_word !== want_beat.word ||
                    o_slot_verdict !== want_beat.verdict || o_last_word !== want_beat.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected kind=%0d word=%h verdict=%0d last=%0d",
                                 want_beat.kind, want_beat.word, want_beat.verdict,
                                 want_beat.last);
                        $display("          actual   kind=%0d word=%h verdict=%0d last=%0d",
                                 o_result_kind, o_packed_word, o_slot_verdict, o_last_word);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no beat moved for %0d cycles, %0d beats outstanding",
                     idle_cycles, pending_beats.size());
            $display("[dual_crc_record_codec_core] ERROR");
            $finish;
        end
    end

    // All-zero field values in a pack
    task automatic test_pack_extremes();
        send_pack('0);
    endtask

    // Erased slot reads as empty
    task automatic test_erased_slot();
        for (int k = 0; k < RECORD_WORDS; k++) begin
            send_slot(ERASED_WORD);
        end
    endtask

    // A pack in the middle of a check restarts the word count
    task automatic test_pack_abandons_check(input fields_t f);
        send_slot(32'h1234_5678);
        send_slot(ERASED_WORD);
        send_pack(f);
    endtask

    task automatic test_good_record(input record_t rec);
        send_slot_record(rec);
    endtask

    // Damaged data byte fails the head CRC
    task automatic test_head_crc_fail(input record_t rec);
        rec[3][12] = ~rec[3][12];
        send_slot_record(rec);
    endtask

    // Damaged tail CRC with an intact head
    task automatic test_tail_crc_fail(input record_t rec);
        rec[RECORD_WORDS-1][31] = ~rec[RECORD_WORDS-1][31];
        send_slot_record(rec);
    endtask

    // Random traffic: mostly well-formed records, some damaged, some noise
    task automatic test_random_traffic();
        record_t     rec;
        int unsigned pick;
        int unsigned n;
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            src_steady  = ($urandom_range(0, 9) == 0);
            sink_steady = ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 99);
            rec  = build_record(rand_fields());
            if (pick < 20) begin
                send_pack(rand_fields());
            end else if (pick < 55) begin
                send_slot_record(rec);
            end else if (pick < 72) begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        rec[RECORD_WORDS-1][$urandom_range(16, 31)] ^= 1'b1;
                    end else begin
                        rec[$urandom_range(0, RECORD_WORDS-1)][$urandom_range(0, 31)] ^= 1'b1;
                    end
                end
                send_slot_record(rec);
            end else if (pick < 80) begin
                rec = '1;
                if ($urandom_range(0, 1) == 0) begin
                    rec[$urandom_range(0, RECORD_WORDS-1)][8*$urandom_range(0, 3) +: 8] =
                        8'($urandom_range(0, 254));
                end
                send_slot_record(rec);
            end else if (pick < 90) begin
                n = $urandom_range(1, RECORD_WORDS-1);
                for (int j = 0; j < n; j++) begin
                    send_slot(rec[j]);
                end
                send_pack(rand_fields());
            end else begin
                n = $urandom_range(1, RECORD_WORDS);
                for (int j = 0; j < n; j++) begin
                    send_slot(rand_word());
                end
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Test sequence
    initial begin
        fields_t mixed;
        record_t mixed_rec;
        for (int v = 0; v < 4; v++) begin
            verdict_seen[v] = 0;
        end
        clear_checker();
        mixed = {32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5,
                 32'h8000_0000, 32'hAAAA_AAAA, 32'h0000_0001};
        mixed_rec = build_record(mixed);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pack_extremes();
        test_erased_slot();
        test_pack_abandons_check(mixed);
        test_good_record(mixed_rec);
        test_head_crc_fail(mixed_rec);
        test_tail_crc_fail(mixed_rec);
        test_random_traffic();
        i_valid <= 1'b0;

        while (pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d items in, %0d record words out", items_sent, words_seen);
        $display("slot verdicts: empty %0d, half written %0d, unfinished %0d, ok %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("[dual_crc_record_codec_core] OK");
        end else begin
            $display("%0d mismatches, %0d beats never arrived", errors, pending_beats.size());
            $display("[dual_crc_record_codec_core] ERROR");
        end
        $finish;
    end

endmodule
